FILE: src/life_grid_generation_step_assert.svh
// Assertion macros shared by the grid step RTL.
`ifndef LIFE_GRID_GENERATION_STEP_ASSERT_SVH
`define LIFE_GRID_GENERATION_STEP_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define LGS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define LGS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/lgs_pkg.sv
`timescale 1ns / 1ps

package lgs_pkg;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_GRID_COLS = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_GRID_ROWS = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_AGE_LIMIT = 2'd2;

	localparam logic [6:0]  GRID_COLS_RST = 7'd64;
	localparam logic [6:0]  GRID_ROWS_RST = 7'd64;
	localparam logic [15:0] AGE_LIMIT_RST = 16'd100;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_GEN   = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [5:0] col;
		logic [5:0] row;
		logic       alive_in;
	} cmd_t;

	typedef struct packed {
		logic        cell_live;
		logic [15:0] cell_age;
	} rsp_t;

endpackage

FILE: src/lgs_ram.sv
`timescale 1ns / 1ps

module lgs_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/lgs_wrap.sv
`timescale 1ns / 1ps

// Reduce x modulo m by repeated subtraction, one step a cycle.
module lgs_wrap #(
	parameter int XW = 6,
	parameter int MW = 7,
	parameter int YW = 6,
	localparam int WW = (XW > MW) ? XW : MW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [XW-1:0] x,
	input  logic [MW-1:0] m,
	output logic          busy,
	output logic [YW-1:0] y
);

	logic [WW-1:0] val_q;
	logic          busy_q;
	logic          ge;

	assign ge   = val_q >= WW'(m);
	assign busy = busy_q;
	assign y    = val_q[YW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && !ge) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= WW'(x);
		end else if (busy_q && ge) begin
			val_q <= val_q - WW'(m);
		end
	end

endmodule

FILE: src/life_grid_generation_step.sv
`timescale 1ns / 1ps

// Toroidal life grid with ageing cells. A command is taken when start is high
// and busy is low; it writes a cell, reads a cell or runs one generation, and
// always returns the addressed cell (alive bit and age) on rsp for exactly one
// cycle with done high. The receiver cannot stall, so sample rsp whenever done
// is seen. busy stays high from the accepted command until done.
// After reset a clearing pass zeroes all MAX_COLS*MAX_ROWS entries of the cell
// memories; busy is high meanwhile, configuration writes are taken as ever.
// Sequence: col and row are first reduced modulo the grid size by subtraction,
// then the cell is fetched and presented on rsp with done high.
// A generation adds, per cell in use, a scan that reads the nine alive bits
// through the single alive memory read port and a decision, a marking pass
// over the neighbours of each exploding cell, then a pass that applies the
// marks cell by cell and a drain of the last write-back.
// Configure only while busy is low.
module life_grid_generation_step #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64,
	parameter int AGE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  lgs_pkg::cmd_t                  cmd,
	output logic                           done,
	output lgs_pkg::rsp_t                  rsp,
	input  logic                           cfg_we,
	input  logic [lgs_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [lgs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

`include "life_grid_generation_step_assert.svh"

	localparam int CW    = $clog2(MAX_COLS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CNW   = $clog2(MAX_COLS + 1);
	localparam int RNW   = $clog2(MAX_ROWS + 1);
	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);

	// Neighbour walk: nine positions, centre is the cell itself.
	localparam logic [3:0] NB_CENTRE = 4'd4;
	localparam logic [3:0] NB_LAST   = 4'd8;
	localparam logic [3:0] NB_COUNT  = 4'd9;

	typedef enum logic [9:0] {
		ST_CLEAR  = 10'b0000000001,
		ST_IDLE   = 10'b0000000010,
		ST_WRAP   = 10'b0000000100,
		ST_SCAN   = 10'b0000001000,
		ST_DECIDE = 10'b0000010000,
		ST_BORN   = 10'b0000100000,
		ST_APPLY  = 10'b0001000000,
		ST_DRAIN  = 10'b0010000000,
		ST_FETCH  = 10'b0100000000,
		ST_OUT    = 10'b1000000000
	} state_t;

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
			input logic [CW-1:0] c);
		return AW'(r) * AW'(MAX_COLS) + AW'(c);
	endfunction

	state_t          state_q;
	logic [6:0]      grid_cols_q;
	logic [6:0]      grid_rows_q;
	logic [15:0]     age_limit_q;
	logic [1:0]      act_q;
	logic            alive_q;
	logic [AW-1:0]   clr_q;
	logic [RW-1:0]   sr_q;
	logic [CW-1:0]   sc_q;
	logic [3:0]      nb_q;
	logic [3:0]      cnt_q;
	logic            self_q;
	logic            rd_v_s1;
	logic [3:0]      rd_j_s1;
	logic            ap_v_s1;
	logic [AW-1:0]   ap_a_s1;

	logic            accept;
	logic [CNW-1:0]  used_cols;
	logic [RNW-1:0]  used_rows;
	logic [CNW-1:0]  cols_m1;
	logic [RNW-1:0]  rows_m1;
	logic [CW-1:0]   last_col;
	logic [RW-1:0]   last_row;
	logic [RW-1:0]   rm1, rp1, nb_row, sr_next;
	logic [CW-1:0]   cm1, cp1, nb_col, sc_next;
	logic            last_cell;
	logic [AW-1:0]   own_addr, nb_addr, k_addr;
	logic            col_busy, row_busy, wrap_done, do_write;
	logic [CW-1:0]   col_w;
	logic [RW-1:0]   row_w;

	logic            alive_we, alive_wd, alive_rd;
	logic [AW-1:0]   alive_wa, alive_ra;
	logic            age_we;
	logic [AW-1:0]   age_wa, age_ra;
	logic [AGE_BITS-1:0] age_wd, age_rd, new_age;
	logic            kill_we, kill_wd, kill_rd;
	logic            born_we, born_wd, born_rd;
	logic [AW-1:0]   mark_wa;

	logic            crowd, age_over, dec_kill, dec_explode, dec_born;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = state_q != ST_IDLE;
	assign done   = state_q == ST_OUT;

	always_comb begin
		rsp.cell_live = alive_rd;
		rsp.cell_age  = 16'(age_rd);
	end

	// Clamp the configured grid size to at least 3 and at most the storage limits.
	always_comb begin
		if (grid_cols_q < 7'd3) begin
			used_cols = CNW'(3);
		end else if (32'(grid_cols_q) > MAX_COLS) begin
			used_cols = CNW'(MAX_COLS);
		end else begin
			used_cols = CNW'(grid_cols_q);
		end
		if (grid_rows_q < 7'd3) begin
			used_rows = RNW'(3);
		end else if (32'(grid_rows_q) > MAX_ROWS) begin
			used_rows = RNW'(MAX_ROWS);
		end else begin
			used_rows = RNW'(grid_rows_q);
		end
	end

	assign cols_m1  = used_cols - CNW'(1);
	assign rows_m1  = used_rows - RNW'(1);
	assign last_col = cols_m1[CW-1:0];
	assign last_row = rows_m1[RW-1:0];

	// Wrapped neighbour coordinates of the scan position.
	assign rm1 = (sr_q == '0) ? last_row : sr_q - RW'(1);
	assign rp1 = (sr_q == last_row) ? '0 : sr_q + RW'(1);
	assign cm1 = (sc_q == '0) ? last_col : sc_q - CW'(1);
	assign cp1 = (sc_q == last_col) ? '0 : sc_q + CW'(1);

	always_comb begin
		priority if (nb_q < 4'd3) begin
			nb_row = rm1;
		end else if (nb_q < 4'd6) begin
			nb_row = sr_q;
		end else begin
			nb_row = rp1;
		end
		unique case (nb_q)
			4'd0, 4'd3, 4'd6: nb_col = cm1;
			4'd2, 4'd5, 4'd8: nb_col = cp1;
			default:          nb_col = sc_q;
		endcase
	end

	// Raster order over the cells in use.
	assign last_cell = (sc_q == last_col) && (sr_q == last_row);
	always_comb begin
		if (sc_q == last_col) begin
			sc_next = '0;
			sr_next = (sr_q == last_row) ? '0 : sr_q + RW'(1);
		end else begin
			sc_next = sc_q + CW'(1);
			sr_next = sr_q;
		end
	end

	assign own_addr = cell_addr(sr_q, sc_q);
	assign nb_addr  = cell_addr(nb_row, nb_col);
	assign k_addr   = cell_addr(row_w, col_w);

	lgs_wrap #(.XW(6), .MW(CNW), .YW(CW)) u_col_wrap (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.x      (cmd.col),
		.m      (used_cols),
		.busy   (col_busy),
		.y      (col_w)
	);

	lgs_wrap #(.XW(6), .MW(RNW), .YW(RW)) u_row_wrap (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.x      (cmd.row),
		.m      (used_rows),
		.busy   (row_busy),
		.y      (row_w)
	);

	assign wrap_done = (state_q == ST_WRAP) && !col_busy && !row_busy;
	assign do_write  = wrap_done && (act_q == lgs_pkg::ACT_WRITE);

	// Per-cell decision once all nine alive bits are in.
	assign new_age     = age_rd + AGE_BITS'(1);
	assign crowd       = (cnt_q < 4'd2) || (cnt_q > 4'd3);
	assign age_over    = 16'(new_age) > age_limit_q;
	assign dec_kill    = self_q && (crowd || age_over);
	assign dec_explode = self_q && !crowd && age_over;
	assign dec_born    = !self_q && (cnt_q == 4'd3);

	// Alive memory: read neighbours while scanning, else the addressed cell.
	assign alive_ra = (state_q == ST_SCAN) ? nb_addr : k_addr;
	always_comb begin
		alive_we = 1'b0;
		alive_wa = k_addr;
		alive_wd = alive_q;
		priority if (state_q == ST_CLEAR) begin
			alive_we = 1'b1;
			alive_wa = clr_q;
			alive_wd = 1'b0;
		end else if (ap_v_s1) begin
			alive_we = kill_rd || born_rd;
			alive_wa = ap_a_s1;
			alive_wd = !kill_rd;
		end else if (do_write) begin
			alive_we = 1'b1;
		end
	end

	assign age_ra = (state_q == ST_SCAN) ? own_addr : k_addr;
	always_comb begin
		age_we = 1'b0;
		age_wa = k_addr;
		age_wd = '0;
		priority if (state_q == ST_CLEAR) begin
			age_we = 1'b1;
			age_wa = clr_q;
		end else if (ap_v_s1) begin
			age_we = kill_rd;
			age_wa = ap_a_s1;
		end else if (state_q == ST_DECIDE) begin
			age_we = self_q;
			age_wa = own_addr;
			age_wd = new_age;
		end else if (do_write) begin
			age_we = 1'b1;
		end
	end

	// Mark memories are set during the scan and cleared as they are applied.
	always_comb begin
		kill_we = 1'b0;
		kill_wd = 1'b0;
		born_we = 1'b0;
		born_wd = 1'b0;
		mark_wa = own_addr;
		priority if (state_q == ST_CLEAR) begin
			kill_we = 1'b1;
			born_we = 1'b1;
			mark_wa = clr_q;
		end else if (ap_v_s1) begin
			kill_we = 1'b1;
			born_we = 1'b1;
			mark_wa = ap_a_s1;
		end else if (state_q == ST_DECIDE) begin
			kill_we = dec_kill;
			kill_wd = 1'b1;
			born_we = dec_born;
			born_wd = 1'b1;
		end else if (state_q == ST_BORN) begin
			born_we = nb_q != NB_CENTRE;
			born_wd = 1'b1;
			mark_wa = nb_addr;
		end
	end

	lgs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_alive_ram (
		.clk (clk), .we (alive_we), .waddr (alive_wa), .wdata (alive_wd),
		.raddr (alive_ra), .rdata (alive_rd)
	);

	lgs_ram #(.WIDTH(AGE_BITS), .DEPTH(DEPTH)) u_age_ram (
		.clk (clk), .we (age_we), .waddr (age_wa), .wdata (age_wd),
		.raddr (age_ra), .rdata (age_rd)
	);

	lgs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_kill_ram (
		.clk (clk), .we (kill_we), .waddr (mark_wa), .wdata (kill_wd),
		.raddr (own_addr), .rdata (kill_rd)
	);

	lgs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_born_ram (
		.clk (clk), .we (born_we), .waddr (mark_wa), .wdata (born_wd),
		.raddr (own_addr), .rdata (born_rd)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= lgs_pkg::GRID_COLS_RST;
			grid_rows_q <= lgs_pkg::GRID_ROWS_RST;
			age_limit_q <= lgs_pkg::AGE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				lgs_pkg::REG_GRID_COLS: grid_cols_q <= cfg_wdata[6:0];
				lgs_pkg::REG_GRID_ROWS: grid_rows_q <= cfg_wdata[6:0];
				lgs_pkg::REG_AGE_LIMIT: age_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Hold the command payload for the length of the transfer's work.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= cmd.action;
			alive_q <= cmd.alive_in;
		end
		ap_a_s1 <= own_addr;
		rd_j_s1 <= nb_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			sr_q    <= '0;
			sc_q    <= '0;
			nb_q    <= '0;
			cnt_q   <= '0;
			self_q  <= 1'b0;
			rd_v_s1 <= 1'b0;
			ap_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_SCAN) && (nb_q != NB_COUNT);
			ap_v_s1 <= state_q == ST_APPLY;
			// Gather alive bits as they return from the memory.
			if (rd_v_s1) begin
				if (rd_j_s1 == NB_CENTRE) begin
					self_q <= alive_rd;
				end else begin
					cnt_q <= cnt_q + 4'(alive_rd);
				end
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					if (wrap_done) begin
						if (act_q == lgs_pkg::ACT_GEN) begin
							sr_q    <= '0;
							sc_q    <= '0;
							nb_q    <= '0;
							cnt_q   <= '0;
							self_q  <= 1'b0;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_SCAN: begin
					if (nb_q == NB_COUNT) begin
						state_q <= ST_DECIDE;
					end else begin
						nb_q <= nb_q + 4'd1;
					end
				end
				ST_DECIDE, ST_BORN: begin
					if ((state_q == ST_DECIDE) && dec_explode) begin
						nb_q    <= '0;
						state_q <= ST_BORN;
					end else if ((state_q == ST_BORN) && (nb_q != NB_LAST)) begin
						nb_q <= nb_q + 4'd1;
					end else begin
						// Advance to the next cell, or start applying marks.
						sr_q    <= sr_next;
						sc_q    <= sc_next;
						nb_q    <= '0;
						cnt_q   <= '0;
						self_q  <= 1'b0;
						state_q <= last_cell ? ST_APPLY : ST_SCAN;
					end
				end
				ST_APPLY: begin
					sr_q <= sr_next;
					sc_q <= sc_next;
					if (last_cell) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_FETCH;
				ST_FETCH: state_q <= ST_OUT;
				ST_OUT:   state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	`LGS_ASSERT_NEXT(a_fetch_done, clk, arst_n, state_q == ST_FETCH, done, "fetch not followed by done")
	`LGS_ASSERT_IMP(a_scan_data, clk, arst_n, rd_v_s1, state_q == ST_SCAN, "neighbour data outside scan")
	`LGS_ASSERT_IMP(a_apply_wb, clk, arst_n, ap_v_s1, (state_q == ST_APPLY) || (state_q == ST_DRAIN), "mark write-back outside apply")
	`LGS_ASSERT_IMP(a_count_max, clk, arst_n, state_q == ST_DECIDE, cnt_q <= 4'd8, "neighbour count above eight")

endmodule
